FILE: rtl/core/gcr_sector_encoder_assert.svh
// assertion macros shared by the checker files of the gcr sector encoder
`ifndef GCR_SECTOR_ENCODER_ASSERT_SVH
`define GCR_SECTOR_ENCODER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define GCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gcr_pkg.sv
// shared types, constants and coding functions of the gcr sector encoder
package gcr_pkg;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] REG_ID_FIRST  = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_ID_SECOND = 1'b1;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] GAP_BYTE  = 8'h55;
  localparam logic [7:0] HDR_MARK  = 8'h08;
  localparam logic [7:0] DATA_MARK = 8'h07;
  localparam logic [7:0] HDR_FILL  = 8'h0F;

  // output layout of the sector preamble
  localparam logic [4:0] SYNC_LEN   = 5'd5;
  localparam logic [4:0] HDR_END    = 5'd15;
  localparam logic [4:0] GAP_END    = 5'd24;
  localparam logic [4:0] HEAD_LEN   = 5'd29;
  localparam logic [4:0] GROUP_LEN  = 5'd5;

  // tail gap by track zone
  localparam logic [5:0] ZONE1_TRACK = 6'd18;
  localparam logic [5:0] ZONE2_TRACK = 6'd25;
  localparam logic [5:0] ZONE3_TRACK = 6'd31;
  localparam logic [4:0] GAP_ZONE0   = 5'd8;
  localparam logic [4:0] GAP_ZONE1   = 5'd17;
  localparam logic [4:0] GAP_ZONE2   = 5'd12;
  localparam logic [4:0] GAP_ZONE3   = 5'd9;

  typedef enum logic [1:0] {
    JOB_HEAD,
    JOB_DATA,
    JOB_TAIL
  } job_kind_e;

  // one burst of output bytes; payload bytes leave msb first
  typedef struct packed {
    job_kind_e   kind;
    logic [79:0] payload;
    logic [4:0]  len;
  } job_t;

  function automatic logic [4:0] gcr_nibble(input logic [3:0] nib);
    logic [4:0] code;
    unique case (nib)
      4'h0: code = 5'h0a;
      4'h1: code = 5'h0b;
      4'h2: code = 5'h12;
      4'h3: code = 5'h13;
      4'h4: code = 5'h0e;
      4'h5: code = 5'h0f;
      4'h6: code = 5'h16;
      4'h7: code = 5'h17;
      4'h8: code = 5'h09;
      4'h9: code = 5'h19;
      4'ha: code = 5'h1a;
      4'hb: code = 5'h1b;
      4'hc: code = 5'h0d;
      4'hd: code = 5'h1d;
      4'he: code = 5'h1e;
      4'hf: code = 5'h15;
      default: code = 5'h0a;
    endcase
    return code;
  endfunction

  function automatic logic [9:0] gcr_code(input logic [7:0] b);
    return {gcr_nibble(b[7:4]), gcr_nibble(b[3:0])};
  endfunction

endpackage

FILE: rtl/core/gcr_sector_encoder.sv
// top level of the gcr sector encoder
// Encodes one floppy sector in the group code recording format: the 256 data
// bytes enter one per transfer, byte 0 carrying the sector and track numbers.
// Byte 0 yields the preamble (5 sync bytes, the 4-to-5 coded header block of
// 10 bytes, 9 gap bytes, 5 sync bytes), 29 output transfers. Each later data
// byte is coded to 10 bits; every fourth code completes a group that leaves as
// 5 bytes, and bytes that complete no group yield no output at all. Byte 255
// closes the data block with the checksum and two zero bytes and appends a
// 0x55 tail gap of 8, 17, 12 or 9 bytes by track zone, flagged on its last
// byte by tuser. tlast marks the final output of every byte that yields output.
// Timing: a data byte that completes no group is taken whenever the pending
// slot is free or being emptied, even while earlier output is pending; one
// that completes a group occupies the emitter for its 5 output bytes, byte 0
// for its 29 and byte 255 for its 13 to 22. The single output port, one byte
// per cycle while the downstream side is ready, sets the rate. The input side
// holds one burst in a pending slot while the emitter works on the previous
// one, and the emitter refills its output register as each byte is taken.
// Disk identifiers are written over the cfg channel (index 0 first id, index
// 1 second id), which is always ready; write them only while no sector is in
// flight.
module gcr_sector_encoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input stream
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [23:0]                  s_axis_tdata_i,  // data_byte[7:0], sector_number[12:8],
                                                        // track_number[18:13], zero [23:19]
  // output stream
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [7:0]                   m_axis_tdata_o,  // gcr_byte[7:0]
  output logic                         m_axis_tlast_o,  // last_of_run
  output logic                         m_axis_tuser_o,  // sector_end[0]
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gcr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gcr_pkg::CfgDataW-1:0] cfg_data_i
);

  // disk identifier registers
  logic [7:0] id_first_q, id_second_q;

  // pending burst slot between framer and emitter
  logic          pend_valid_q;
  gcr_pkg::job_t pend_job_q;
  logic          pend_take;

  logic          in_xfer;
  logic          job_valid;
  gcr_pkg::job_t job;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = !pend_valid_q || pend_take;
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_first_q  <= 8'd0;
      id_second_q <= 8'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        gcr_pkg::REG_ID_FIRST:  id_first_q  <= cfg_data_i;
        gcr_pkg::REG_ID_SECOND: id_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // position, checksum and code packing; builds one burst per producing byte
  gcr_framer u_framer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_xfer),
    .data_i      (s_axis_tdata_i[7:0]),
    .sector_i    (s_axis_tdata_i[12:8]),
    .track_i     (s_axis_tdata_i[18:13]),
    .id_first_i  (id_first_q),
    .id_second_i (id_second_q),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  // a new burst may land in the slot the same cycle the emitter takes the old one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (in_xfer && job_valid) begin
      pend_valid_q <= 1'b1;
    end else if (pend_take) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && job_valid) begin
      pend_job_q <= job;
    end
  end

  gcr_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pend_valid_i (pend_valid_q),
    .pend_job_i   (pend_job_q),
    .pend_take_o  (pend_take),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (m_axis_tdata_o),
    .out_last_o   (m_axis_tlast_o),
    .out_end_o    (m_axis_tuser_o)
  );

endmodule

FILE: rtl/core/gcr_framer.sv
// sector position tracking, checksum, code packing and burst building
module gcr_framer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_i,
  input  logic [4:0]           sector_i,
  input  logic [5:0]           track_i,
  input  logic [7:0]           id_first_i,
  input  logic [7:0]           id_second_i,
  output logic                 job_valid_o,
  output gcr_pkg::job_t        job_o
);

  logic [7:0]  pos_q, pos_d;
  logic [7:0]  chk_q, chk_d;
  logic [29:0] pend_q, pend_d;
  logic [5:0]  track_q, track_d;

  logic        first, last, group_full;
  logic [7:0]  hdr_check;
  logic [9:0]  data_code;
  logic [4:0]  gap_len;

  assign first      = (pos_q == 8'd0);
  assign last       = (pos_q == 8'd255);
  assign group_full = !first && (pos_q[1:0] == 2'd2);
  assign hdr_check  = {3'b0, sector_i} ^ {2'b0, track_i} ^ id_first_i ^ id_second_i;
  assign data_code  = gcr_pkg::gcr_code(data_i);

  always_comb begin
    priority if (track_q < gcr_pkg::ZONE1_TRACK) gap_len = gcr_pkg::GAP_ZONE0;
    else if (track_q < gcr_pkg::ZONE2_TRACK)     gap_len = gcr_pkg::GAP_ZONE1;
    else if (track_q < gcr_pkg::ZONE3_TRACK)     gap_len = gcr_pkg::GAP_ZONE2;
    else                                         gap_len = gcr_pkg::GAP_ZONE3;
  end

  always_comb begin
    chk_d   = (first ? 8'd0 : chk_q) ^ data_i;
    track_d = first ? track_i : track_q;
    pos_d   = pos_q + 8'd1;
    pend_d  = {pend_q[19:0], data_code};
    job_valid_o   = first || group_full || last;
    job_o.kind    = gcr_pkg::JOB_DATA;
    job_o.len     = gcr_pkg::GROUP_LEN;
    job_o.payload = {pend_q, data_code, 40'b0};
    if (first) begin
      job_o.kind    = gcr_pkg::JOB_HEAD;
      job_o.len     = gcr_pkg::HEAD_LEN;
      job_o.payload = {gcr_pkg::gcr_code(gcr_pkg::HDR_MARK), gcr_pkg::gcr_code(hdr_check),
                       gcr_pkg::gcr_code({3'b0, sector_i}), gcr_pkg::gcr_code({2'b0, track_i}),
                       gcr_pkg::gcr_code(id_second_i), gcr_pkg::gcr_code(id_first_i),
                       gcr_pkg::gcr_code(gcr_pkg::HDR_FILL),
                       gcr_pkg::gcr_code(gcr_pkg::HDR_FILL)};
      // data mark and byte 0 wait for two more codes
      pend_d = {10'b0, gcr_pkg::gcr_code(gcr_pkg::DATA_MARK), data_code};
    end else if (last) begin
      // group is empty here: byte 255, checksum and two zero bytes close it
      job_o.kind    = gcr_pkg::JOB_TAIL;
      job_o.len     = gcr_pkg::GROUP_LEN + gap_len;
      job_o.payload = {data_code, gcr_pkg::gcr_code(chk_d), gcr_pkg::gcr_code(8'd0),
                       gcr_pkg::gcr_code(8'd0), 40'b0};
      pend_d = 30'b0;
      pos_d  = 8'd0;
    end else if (group_full) begin
      pend_d = 30'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 8'd0;
      chk_q   <= 8'd0;
      pend_q  <= 30'b0;
      track_q <= 6'd0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      chk_q   <= chk_d;
      pend_q  <= pend_d;
      track_q <= track_d;
    end
  end

endmodule

FILE: rtl/core/gcr_emitter.sv
// walks one burst at a time and drives the registered output stage
module gcr_emitter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pend_valid_i,
  input  gcr_pkg::job_t pend_job_i,
  output logic          pend_take_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_last_o,
  output logic          out_end_o
);

  logic           act_q;
  gcr_pkg::job_t  job_q;
  logic [4:0]     idx_q;
  logic           ov_q;
  logic [7:0]     obyte_q;
  logic           olast_q, oend_q;

  logic           fire, done, load;
  logic [3:0]     bsel;
  logic [9:0][7:0] pbytes;
  logic [7:0]     pbyte, next_byte;

  assign fire        = act_q && (!ov_q || out_ready_i);
  assign done        = (idx_q == job_q.len - 5'd1);
  assign load        = !act_q || (fire && done);
  assign pend_take_o = pend_valid_i && load;

  assign pbytes = job_q.payload;
  assign bsel   = (job_q.kind == gcr_pkg::JOB_HEAD) ? 4'(idx_q - gcr_pkg::SYNC_LEN)
                                                    : idx_q[3:0];
  assign pbyte  = pbytes[4'd9 - bsel];

  always_comb begin
    unique case (job_q.kind)
      gcr_pkg::JOB_HEAD: begin
        priority if (idx_q < gcr_pkg::SYNC_LEN) next_byte = gcr_pkg::SYNC_BYTE;
        else if (idx_q < gcr_pkg::HDR_END)      next_byte = pbyte;
        else if (idx_q < gcr_pkg::GAP_END)      next_byte = gcr_pkg::GAP_BYTE;
        else                                    next_byte = gcr_pkg::SYNC_BYTE;
      end
      gcr_pkg::JOB_TAIL: begin
        next_byte = (idx_q < gcr_pkg::GROUP_LEN) ? pbyte : gcr_pkg::GAP_BYTE;
      end
      default: next_byte = pbyte;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      idx_q <= 5'd0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        act_q <= pend_valid_i;
        idx_q <= 5'd0;
      end else if (fire) begin
        idx_q <= idx_q + 5'd1;
      end
      if (fire) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= pend_job_i;
    end
    if (fire) begin
      obyte_q <= next_byte;
      olast_q <= done;
      oend_q  <= done && (job_q.kind == gcr_pkg::JOB_TAIL);
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign out_end_o   = oend_q;

endmodule

FILE: rtl/core/gcr_checker.sv
// port-level checks of the gcr sector encoder and their binding
`include "gcr_sector_encoder_assert.svh"

module gcr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tuser_o
);

  // a stalled output transfer keeps its byte and flags
  `GCR_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o), "output changed while stalled")

  // sector end is always the final byte of its run
  `GCR_ASSERT_NOW(a_end_is_last, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tlast_o, "sector end without tlast")

  // sector end falls on a tail gap byte
  `GCR_ASSERT_NOW(a_end_is_gap, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o == 8'h55, "sector end not on gap byte")

endmodule

bind gcr_sector_encoder gcr_checker u_gcr_checker (.*);

FILE: tb/tb_gcr_sector_encoder.sv
// self-checking testbench for the gcr sector encoder
module tb_gcr_sector_encoder;
  timeunit 1ns;
  timeprecision 1ps;

  // far above the slowest correct run: 2 sectors under heavy idling on both sides
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned NumSectors = 2;
  localparam int unsigned DrainWait  = 40;

  // 4-to-5 group codes, code of nibble n at bits [5n+4:5n]
  localparam logic [79:0] GcrCodes = {
    5'h15, 5'h1e, 5'h1d, 5'h0d, 5'h1b, 5'h1a, 5'h19, 5'h09,
    5'h17, 5'h16, 5'h0f, 5'h0e, 5'h13, 5'h12, 5'h0b, 5'h0a
  };

  typedef struct packed {
    logic [7:0] gcr_byte;
    logic       last_of_run;
    logic       sector_end;
  } track_byte_t;

  // predicts the recorded byte stream and checks the block's output against it
  class sector_stream_model;
    logic [7:0]  id_first;
    logic [7:0]  id_second;
    logic [7:0]  position;
    logic [7:0]  checksum;
    logic [29:0] held_codes;
    int unsigned held_count;
    logic [5:0]  held_track;
    track_byte_t track_bytes_q[$];
    int unsigned mismatch_count;

    function new();
      id_first       = '0;
      id_second      = '0;
      position       = '0;
      checksum       = '0;
      held_codes     = '0;
      held_count     = 0;
      held_track     = '0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [gcr_pkg::CfgIdxW-1:0] idx, logic [7:0] val);
      if (idx == gcr_pkg::REG_ID_FIRST) begin
        id_first = val;
      end else if (idx == gcr_pkg::REG_ID_SECOND) begin
        id_second = val;
      end
    endfunction

    function void put_byte(logic [7:0] v);
      track_byte_t tb_byte;
      tb_byte.gcr_byte    = v;
      tb_byte.last_of_run = 1'b0;
      tb_byte.sector_end  = 1'b0;
      track_bytes_q = {track_bytes_q, tb_byte};
    endfunction

    // four coded bytes make 40 bits, sent as five bytes msb first
    function void put_coded(logic [7:0] b);
      logic [39:0] acc;
      acc = {held_codes, GcrCodes[int'(b[7:4])*5 +: 5], GcrCodes[int'(b[3:0])*5 +: 5]};
      held_count++;
      if (held_count == 4) begin
        put_byte(acc[39:32]);
        put_byte(acc[31:24]);
        put_byte(acc[23:16]);
        put_byte(acc[15:8]);
        put_byte(acc[7:0]);
        held_codes = '0;
        held_count = 0;
      end else begin
        held_codes = acc[29:0];
      end
    endfunction

    function void take_source_byte(logic [7:0] data, logic [4:0] sector, logic [5:0] track);
      int unsigned first_idx;
      int unsigned gap_len;
      track_byte_t tail;
      first_idx = track_bytes_q.size();
      if (position == 8'd0) begin
        held_track = track;
        checksum   = '0;
        held_codes = '0;
        held_count = 0;
        repeat (5) put_byte(gcr_pkg::SYNC_BYTE);
        put_coded(gcr_pkg::HDR_MARK);
        put_coded({3'b0, sector} ^ {2'b0, track} ^ id_first ^ id_second);
        put_coded({3'b0, sector});
        put_coded({2'b0, track});
        put_coded(id_second);
        put_coded(id_first);
        put_coded(gcr_pkg::HDR_FILL);
        put_coded(gcr_pkg::HDR_FILL);
        repeat (9) put_byte(gcr_pkg::GAP_BYTE);
        repeat (5) put_byte(gcr_pkg::SYNC_BYTE);
        put_coded(gcr_pkg::DATA_MARK);
      end
      checksum ^= data;
      put_coded(data);
      if (position == 8'd255) begin
        put_coded(checksum);
        put_coded(8'h00);
        put_coded(8'h00);
        gap_len = (held_track < gcr_pkg::ZONE1_TRACK) ? gcr_pkg::GAP_ZONE0 :
                  (held_track < gcr_pkg::ZONE2_TRACK) ? gcr_pkg::GAP_ZONE1 :
                  (held_track < gcr_pkg::ZONE3_TRACK) ? gcr_pkg::GAP_ZONE2 :
                                                        gcr_pkg::GAP_ZONE3;
        repeat (gap_len) put_byte(gcr_pkg::GAP_BYTE);
        tail = track_bytes_q[track_bytes_q.size() - 1];
        tail.sector_end = 1'b1;
        track_bytes_q[track_bytes_q.size() - 1] = tail;
      end
      position = position + 8'd1;
      if (track_bytes_q.size() > first_idx) begin
        tail = track_bytes_q[track_bytes_q.size() - 1];
        tail.last_of_run = 1'b1;
        track_bytes_q[track_bytes_q.size() - 1] = tail;
      end
    endfunction

    function void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s", msg);
    endfunction

    function void check_track_byte(logic [7:0] b, logic l, logic e);
      track_byte_t want;
      if (track_bytes_q.size() == 0) begin
        note_mismatch($sformatf("unexpected output: byte %02h last %0b end %0b", b, l, e));
      end else begin
        want = track_bytes_q.pop_front();
        if (want.gcr_byte !== b || want.last_of_run !== l || want.sector_end !== e) begin
          note_mismatch($sformatf(
            "output mismatch: expected byte %02h last %0b end %0b, got byte %02h last %0b end %0b",
            want.gcr_byte, want.last_of_run, want.sector_end, b, l, e));
        end
      end
    endfunction
  endclass

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         s_axis_tvalid_i = 1'b0;
  logic                         s_axis_tready_o;
  logic [23:0]                  s_axis_tdata_i  = '0;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i = 1'b0;
  logic [7:0]                   m_axis_tdata_o;
  logic                         m_axis_tlast_o;
  logic                         m_axis_tuser_o;
  logic                         cfg_valid_i     = 1'b0;
  logic                         cfg_ready_o;
  logic [gcr_pkg::CfgIdxW-1:0]  cfg_index_i     = '0;
  logic [gcr_pkg::CfgDataW-1:0] cfg_data_i      = '0;

  // 0: no idling, 1: sender idles, 2: receiver stalls, 3: both lightly
  logic [1:0]  idle_mode   = 2'd0;
  int unsigned cycle_count = 0;

  // sector plan: longest tail gap first, then field extremes
  logic [5:0] track_plan  [NumSectors] = '{6'd18, 6'd63};
  logic [4:0] sector_plan [NumSectors] = '{5'd20, 5'd31};

  sector_stream_model model;

  gcr_sector_encoder i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // output side: check each transfer, then pick next cycle's ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      model.check_track_byte(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
    end
    if (idle_mode == 2'd2) begin
      m_axis_tready_i <= ($urandom_range(99) >= 82);
    end else if (idle_mode == 2'd3) begin
      m_axis_tready_i <= ($urandom_range(99) >= 14);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_gcr_sector_encoder failed");
      $finish;
    end
  end

  function automatic bit sender_idles();
    if (idle_mode == 2'd1) return $urandom_range(99) < 82;
    if (idle_mode == 2'd3) return $urandom_range(99) < 14;
    return 1'b0;
  endfunction

  // one input transfer; valid stays high when the next byte follows at once
  task automatic send_source_byte(input logic [7:0] data, input logic [4:0] sector,
                                  input logic [5:0] track);
    while (sender_idles()) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'b0, track, sector, data};
    do @(posedge clk_i); while (!s_axis_tready_o);
    model.take_source_byte(data, sector, track);
  endtask

  task automatic write_cfg(input logic [gcr_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    model.write_reg(idx, val);
  endtask

  // wait for every predicted byte, then let the emitter settle
  task automatic wait_drained();
    while (model.track_bytes_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] id_a;
    logic [7:0] id_b;
    logic [7:0] data;
    model = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int sec = 0; sec < NumSectors; sec++) begin
      // disk ids change only between sectors, extremes first
      case (sec)
        0: begin
          id_a = 8'hFF;
          id_b = 8'h00;
        end
        1: begin
          id_a = 8'h00;
          id_b = 8'hFF;
        end
        2: begin
          id_a = 8'hFF;
          id_b = 8'hFF;
        end
        3: begin
          id_a = 8'h00;
          id_b = 8'h00;
        end
        default: begin
          id_a = 8'($urandom);
          id_b = 8'($urandom);
        end
      endcase
      // second sector keeps the second id of the first one
      write_cfg(gcr_pkg::REG_ID_FIRST, id_a);
      if (sec != 1) write_cfg(gcr_pkg::REG_ID_SECOND, id_b);
      cfg_valid_i <= 1'b0;

      for (int pos = 0; pos < 256; pos++) begin
        if (pos % 64 == 0) begin
          idle_mode <= (sec == 0 && pos == 0) ? 2'd0 : 2'($urandom_range(3));
        end
        // first sector opens with every nibble in both halves, then all zeros and ones
        if (sec == 0 && pos < 16) begin
          data = {4'(pos), ~4'(pos)};
        end else if (sec == 0 && pos == 16) begin
          data = 8'h00;
        end else if (sec == 0 && pos == 17) begin
          data = 8'hFF;
        end else begin
          data = 8'($urandom);
        end
        // sector and track only count with byte 0, elsewhere they are noise
        if (pos == 0) begin
          send_source_byte(data, sector_plan[sec], track_plan[sec]);
        end else begin
          send_source_byte(data, 5'($urandom), 6'($urandom));
        end
      end
      s_axis_tvalid_i <= 1'b0;
      wait_drained();
    end

    if (model.mismatch_count == 0 && model.track_bytes_q.size() == 0) begin
      $display("tb_gcr_sector_encoder passed");
    end else begin
      $display("tb_gcr_sector_encoder failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/gcr_pkg.sv
rtl/core/gcr_framer.sv
rtl/core/gcr_emitter.sv
rtl/core/gcr_sector_encoder.sv
rtl/core/gcr_checker.sv
tb/tb_gcr_sector_encoder.sv
